/* src/bbfe_pkg.sv */
// Package for the bitplane box fill engine.
// Holds geometry constants, payload and control structs, and the FSM state type.
// No dependencies.
`timescale 1ns / 1ps

package bbfe_pkg;

   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_LINES    = 200;
   localparam int GROUPS_PER_LINE = 20;

   localparam int STORE_DEPTH = SCREEN_LINES * GROUPS_PER_LINE;
   localparam int STORE_COLS  = (SCREEN_WIDTH < GROUPS_PER_LINE * 16) ?
                                SCREEN_WIDTH : (GROUPS_PER_LINE * 16);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int COL_W  = $clog2(STORE_COLS + 1);
   localparam int LINE_W = $clog2(SCREEN_LINES + 1);
   localparam int GRP_W  = COL_W - 4;
   localparam int CRD_W  = 13;   // signed working width for clip math

   localparam int CSR_W = 9;

   localparam logic [8:0] CLIP_LEFT_RESET   = 9'd0;
   localparam logic [7:0] CLIP_TOP_RESET    = 8'd0;
   localparam logic [8:0] CLIP_RIGHT_RESET  = 9'd320;
   localparam logic [7:0] CLIP_BOTTOM_RESET = 8'd200;

   localparam logic [1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [1:0] CSR_CLIP_TOP    = 2'd1;
   localparam logic [1:0] CSR_CLIP_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_CLIP_BOTTOM = 2'd3;

   typedef enum logic [1:0] {
      REQ_FILL  = 2'd0,
      REQ_PLOT  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic signed [11:0] rect_width;
      logic signed [11:0] rect_height;
      logic [3:0]         colour;
   } req_item_type;

   typedef struct packed {
      logic [3:0] pixel_value;
      logic       nothing_done;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_FILL_START,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_PIX_RD,
      ST_PIX_WR
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic clear_run;
      logic fill_start;
      logic fill_rd;
      logic fill_wr;
      logic group_step;
      logic line_step;
      logic pix_rd;
      logic pix_wr;
      logic rsp_fire;
      logic rsp_none;
      logic rsp_read;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         fill_empty;
      logic         pix_miss;
      logic         clear_last;
      logic         group_last;
      logic         line_last;
   } dp_status_type;

endpackage

/* src/bitplane_box_fill_engine.sv */
// Bitplane box fill engine: 4-bit pixel frame store held as interleaved
// bitplanes, with clipped rectangle fill, pixel plot, pixel read and clear.
//
// Use: an item is taken on a clock edge with start high and busy low; the
// command is in req_item. Clip registers are written through csr_we,
// csr_index and csr_wdata, one register per cycle; the user must do this
// only while the block is idle, which the block does not enforce.
// Every item gives one result on rsp_item, marked by rsp_strobe for one
// cycle; the receiver must take it then, there is no stall. Per item:
//   fill   one read and one write per 16-pixel group on the single store
//          port pair; no store access when clipped away
//   plot, read  one store entry, read-modify-write for plot; none on a miss
//   clear  STORE_DEPTH (4000) entries, one entry zeroed per cycle
// busy stays high until the result is loaded, and drops as it is shown,
// so the next item can be taken in the strobe cycle.
// Reset: clip box returns to the full screen and the store is swept to zero,
// one entry per cycle, with busy high; CSR writes are taken during the sweep.
// Depends on bbfe_pkg, bbfe_ctrl, bbfe_datapath.
`timescale 1ns / 1ps

module bitplane_box_fill_engine import bbfe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   output logic             rsp_strobe,
   output rsp_item_type     rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bbfe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind_type'(req_item.req_type)),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   bbfe_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // an accepted item always moves the block out of idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a result only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a preceding busy cycle");

   // one result per item, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // a colour is only reported for a successful read
   a_rsp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.pixel_value != 4'd0)) |-> !rsp_item.nothing_done)
      else $error("pixel value reported with nothing_done");

endmodule

/* src/bbfe_ctrl.sv */
// Controller FSM for the bitplane box fill engine.
// Sequences clear sweeps, fill group walks and pixel read-modify-writes.
// Depends on bbfe_pkg.
`timescale 1ns / 1ps

module bbfe_ctrl import bbfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_kind_type  req_kind,
   input  dp_status_type status,
   output logic          busy,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_run = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_kind)
                  REQ_FILL:  state_in = ST_FILL_START;
                  REQ_PLOT,
                  REQ_READ:  state_in = ST_PIX_RD;
                  REQ_CLEAR: state_in = ST_CLEAR;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (status.clear_last) begin
               cmd.rsp_fire = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FILL_START: begin
            if (status.fill_empty) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_none = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.fill_start = 1'b1;
               state_in       = ST_FILL_RD;
            end
         end
         ST_FILL_RD: begin
            cmd.fill_rd = 1'b1;
            state_in    = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            cmd.fill_wr = 1'b1;
            priority if (status.group_last && status.line_last) begin
               cmd.rsp_fire = 1'b1;
               state_in     = ST_IDLE;
            end else if (status.group_last) begin
               cmd.line_step = 1'b1;
               state_in      = ST_FILL_RD;
            end else begin
               cmd.group_step = 1'b1;
               state_in       = ST_FILL_RD;
            end
         end
         ST_PIX_RD: begin
            if (status.pix_miss) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_none = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.pix_rd = 1'b1;
               state_in   = ST_PIX_WR;
            end
         end
         ST_PIX_WR: begin
            cmd.pix_wr   = (status.kind == REQ_PLOT);
            cmd.rsp_read = (status.kind == REQ_READ);
            cmd.rsp_fire = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/bbfe_datapath.sv */
// Datapath for the bitplane box fill engine: clip registers, clip math,
// walk counters, edge masks, the frame store memory and the result register.
// Depends on bbfe_pkg.
`timescale 1ns / 1ps

module bbfe_datapath import bbfe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  req_item_type       req_item,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   output logic               rsp_strobe,
   output rsp_item_type       rsp_item
);

   // clip box registers
   logic [8:0] clip_left_ff, clip_right_ff;
   logic [7:0] clip_top_ff, clip_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= CLIP_LEFT_RESET;
         clip_top_ff    <= CLIP_TOP_RESET;
         clip_right_ff  <= CLIP_RIGHT_RESET;
         clip_bottom_ff <= CLIP_BOTTOM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata[8:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[7:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[8:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[7:0];
         endcase
      end
   end

   // clip math on the incoming item
   logic signed [CRD_W-1:0] in_x, in_y, in_xe, in_ye;
   logic signed [CRD_W-1:0] c_left, c_top, c_right, c_bottom;
   logic signed [CRD_W-1:0] b_right, b_bottom;
   logic signed [CRD_W-1:0] xl, xr, yt, yb;
   logic                    empty_in, plot_miss, read_miss;

   always_comb begin
      in_x     = CRD_W'(req_item.pos_x);
      in_y     = CRD_W'(req_item.pos_y);
      in_xe    = in_x + CRD_W'(req_item.rect_width);
      in_ye    = in_y + CRD_W'(req_item.rect_height);
      c_left   = $signed({4'b0, clip_left_ff});
      c_top    = $signed({5'b0, clip_top_ff});
      c_right  = $signed({4'b0, clip_right_ff});
      c_bottom = $signed({5'b0, clip_bottom_ff});
      b_right  = (c_right < CRD_W'(STORE_COLS)) ? c_right : CRD_W'(STORE_COLS);
      b_bottom = (c_bottom < CRD_W'(SCREEN_LINES)) ? c_bottom : CRD_W'(SCREEN_LINES);

      // clip registers are never negative, so the max with them is the zero floor
      xl = (in_x > c_left) ? in_x : c_left;
      yt = (in_y > c_top) ? in_y : c_top;
      xr = (in_xe < b_right) ? in_xe : b_right;
      yb = (in_ye < b_bottom) ? in_ye : b_bottom;
      empty_in = (xr <= xl) || (yb <= yt);

      plot_miss = (in_x < c_left) || (in_x >= b_right) ||
                  (in_y < c_top) || (in_y >= b_bottom);
      read_miss = (in_x < 0) || (in_x >= CRD_W'(STORE_COLS)) ||
                  (in_y < 0) || (in_y >= CRD_W'(SCREEN_LINES));
   end

   // captured request
   req_kind_type      kind_ff;
   logic [3:0]        colour_ff;
   logic [COL_W-1:0]  x_ff, xl_ff, xr_ff;
   logic [LINE_W-1:0] y_ff, yt_ff, yb_ff;
   logic              empty_ff, miss_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind_type'(req_item.req_type);
         colour_ff <= req_item.colour;
         x_ff      <= in_x[COL_W-1:0];
         y_ff      <= in_y[LINE_W-1:0];
         xl_ff     <= xl[COL_W-1:0];
         xr_ff     <= xr[COL_W-1:0];
         yt_ff     <= yt[LINE_W-1:0];
         yb_ff     <= yb[LINE_W-1:0];
         empty_ff  <= empty_in;
         miss_ff   <= (req_kind_type'(req_item.req_type) == REQ_PLOT) ? plot_miss
                                                                        : read_miss;
      end
   end

   // fill walk counters
   logic [COL_W-1:0]  xr_m1;
   logic [GRP_W-1:0]  g_first, g_last;
   logic [GRP_W-1:0]  g_ff;
   logic [LINE_W-1:0] line_ff;
   logic [ADDR_W-1:0] base_ff;

   assign xr_m1   = xr_ff - 1'b1;
   assign g_first = xl_ff[COL_W-1:4];
   assign g_last  = xr_m1[COL_W-1:4];

   always_ff @(posedge clock) begin
      priority if (cmd.fill_start) begin
         g_ff    <= g_first;
         line_ff <= yt_ff;
         base_ff <= ADDR_W'(yt_ff) * ADDR_W'(GROUPS_PER_LINE);
      end else if (cmd.line_step) begin
         g_ff    <= g_first;
         line_ff <= line_ff + 1'b1;
         base_ff <= base_ff + ADDR_W'(GROUPS_PER_LINE);
      end else if (cmd.group_step) begin
         g_ff <= g_ff + 1'b1;
      end
   end

   // clear sweep counter
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              clr_last;

   assign clr_last = (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_run) begin
         clr_cnt_ff <= clr_last ? '0 : clr_cnt_ff + 1'b1;
      end
   end

   // masks and merge data
   logic [3:0]        mask_a;
   logic [4:0]        mask_b;
   logic [15:0]       edge_m16, pix_m16;
   logic [63:0]       pattern, fill_data, plot_data;
   logic [ADDR_W-1:0] fill_addr, pix_addr;
   logic [63:0]       rd_ff;
   logic [3:0]        pix_val;

   always_comb begin
      mask_a   = (g_ff == g_first) ? xl_ff[3:0] : 4'd0;
      mask_b   = (g_ff == g_last) ? ({1'b0, xr_m1[3:0]} + 5'd1) : 5'd16;
      edge_m16 = (16'hFFFF >> mask_a) & ~(16'hFFFF >> mask_b);
      pix_m16  = 16'h8000 >> x_ff[3:0];
      pattern  = {{16{colour_ff[3]}}, {16{colour_ff[2]}},
                  {16{colour_ff[1]}}, {16{colour_ff[0]}}};
      fill_data = (rd_ff & ~{4{edge_m16}}) | (pattern & {4{edge_m16}});
      plot_data = (rd_ff & ~{4{pix_m16}}) | (pattern & {4{pix_m16}});
      fill_addr = base_ff + ADDR_W'(g_ff);
      pix_addr  = ADDR_W'(y_ff) * ADDR_W'(GROUPS_PER_LINE) + ADDR_W'(x_ff[COL_W-1:4]);
      for (int k = 0; k < 4; k++) begin
         pix_val[k] = |(rd_ff[k*16 +: 16] & pix_m16);
      end
   end

   // frame store
   logic [63:0]       mem [STORE_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [63:0]       wr_data;

   always_comb begin
      wr_en   = cmd.clear_run | cmd.fill_wr | cmd.pix_wr;
      rd_addr = cmd.fill_rd ? fill_addr : pix_addr;
      priority if (cmd.clear_run) begin
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.fill_wr) begin
         wr_addr = fill_addr;
         wr_data = fill_data;
      end else begin
         wr_addr = pix_addr;
         wr_data = plot_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_rd || cmd.pix_rd) rd_ff <= mem[rd_addr];
   end

   // result register
   logic         rsp_strobe_ff;
   rsp_item_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_item_ff.pixel_value  <= cmd.rsp_read ? pix_val : 4'd0;
         rsp_item_ff.nothing_done <= cmd.rsp_none;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      status.kind       = kind_ff;
      status.fill_empty = empty_ff;
      status.pix_miss   = miss_ff;
      status.clear_last = clr_last;
      status.group_last = (g_ff == g_last);
      status.line_last  = (line_ff == LINE_W'(yb_ff - 1'b1));
   end

endmodule

/* test/bbfe_checker.sv */
// Checker for the bitplane box fill engine: watches the command, result and
// clip register ports, keeps its own copy of the frame store and compares.
// Depends on bbfe_pkg.
`timescale 1ns / 1ps

module bbfe_checker import bbfe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_item_type     req_item,
   input  logic             rsp_strobe,
   input  rsp_item_type     rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               waiting_count
);

   logic [63:0]  frame_model [STORE_DEPTH];
   logic [8:0]   clip_l, clip_r;
   logic [7:0]   clip_t, clip_b;
   rsp_item_type pixel_results_q [$];
   rsp_item_type want;

   function automatic int max3(int a, int b, int c);
      int m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic int min3(int a, int b, int c);
      int m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [63:0] colour_planes(logic [3:0] c);
      return {{16{c[3]}}, {16{c[2]}}, {16{c[1]}}, {16{c[0]}}};
   endfunction

   // Applies one command to the model store and returns the result it gives.
   function automatic rsp_item_type run_command(req_item_type it);
      rsp_item_type r;
      int x, y, w, h, xl, xr, yt, yb, lo, a, b, idx, line, g, k;
      logic [15:0] m16;
      logic [63:0] m, pat;
      r = '0;
      x = int'(it.pos_x);
      y = int'(it.pos_y);
      w = int'(it.rect_width);
      h = int'(it.rect_height);
      pat = colour_planes(it.colour);
      case (req_kind_type'(it.req_type))
         REQ_FILL: begin
            xl = max3(x, int'(clip_l), 0);
            xr = min3(x + w, int'(clip_r), STORE_COLS);
            yt = max3(y, int'(clip_t), 0);
            yb = min3(y + h, int'(clip_b), SCREEN_LINES);
            if (xr <= xl || yb <= yt) begin
               r.nothing_done = 1'b1;
            end else begin
               for (line = yt; line < yb; line++) begin
                  for (g = xl >> 4; g <= (xr - 1) >> 4; g++) begin
                     lo = g * 16;
                     a = ((xl > lo) ? xl : lo) - lo;
                     b = ((xr < lo + 16) ? xr : lo + 16) - lo;
                     m16 = (16'hFFFF >> a) & ~(16'hFFFF >> b);
                     m = {4{m16}};
                     idx = line * GROUPS_PER_LINE + g;
                     frame_model[idx] = (frame_model[idx] & ~m) | (pat & m);
                  end
               end
            end
         end
         REQ_PLOT: begin
            xl = max3(int'(clip_l), 0, 0);
            xr = min3(int'(clip_r), STORE_COLS, STORE_COLS);
            yt = max3(int'(clip_t), 0, 0);
            yb = min3(int'(clip_b), SCREEN_LINES, SCREEN_LINES);
            if (x < xl || x >= xr || y < yt || y >= yb) begin
               r.nothing_done = 1'b1;
            end else begin
               idx = y * GROUPS_PER_LINE + (x >> 4);
               m16 = 16'h8000 >> (x & 15);
               m = {4{m16}};
               frame_model[idx] = (frame_model[idx] & ~m) | (pat & m);
            end
         end
         REQ_READ: begin
            if (x < 0 || x >= STORE_COLS || y < 0 || y >= SCREEN_LINES) begin
               r.nothing_done = 1'b1;
            end else begin
               idx = y * GROUPS_PER_LINE + (x >> 4);
               for (k = 0; k < 4; k++)
                  r.pixel_value[k] = frame_model[idx][16 * k + 15 - (x & 15)];
            end
         end
         default: begin
            for (idx = 0; idx < STORE_DEPTH; idx++)
               frame_model[idx] = '0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++)
            frame_model[i] = '0;
         clip_l = CLIP_LEFT_RESET;
         clip_t = CLIP_TOP_RESET;
         clip_r = CLIP_RIGHT_RESET;
         clip_b = CLIP_BOTTOM_RESET;
         pixel_results_q.delete();
         fail_count = 0;
         waiting_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pixel_results_q.size() == 0) begin
               $display("%0t: result with no command waiting: expected none, actual %0h %0b",
                        $time, rsp_item.pixel_value, rsp_item.nothing_done);
               fail_count++;
            end else begin
               want = pixel_results_q.pop_front();
               if (rsp_item.pixel_value !== want.pixel_value) begin
                  $display("%0t: pixel_value expected %0h actual %0h",
                           $time, want.pixel_value, rsp_item.pixel_value);
                  fail_count++;
               end
               if (rsp_item.nothing_done !== want.nothing_done) begin
                  $display("%0t: nothing_done expected %0b actual %0b",
                           $time, want.nothing_done, rsp_item.nothing_done);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CLIP_LEFT:   clip_l = csr_wdata[8:0];
               CSR_CLIP_TOP:    clip_t = csr_wdata[7:0];
               CSR_CLIP_RIGHT:  clip_r = csr_wdata[8:0];
               CSR_CLIP_BOTTOM: clip_b = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (start && busy === 1'b0)
            pixel_results_q.push_back(run_command(req_item));
         waiting_count <= pixel_results_q.size();
      end
   end

endmodule

/* test/testbench.sv */
// Top of the bitplane box fill engine testbench: clock, reset, clip setup,
// directed and random commands, verdict.
// Depends on bbfe_pkg, bitplane_box_fill_engine and bbfe_checker.
`timescale 1ns / 1ps

module testbench;
   import bbfe_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   req_item_type     req_item = '0;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = CSR_CLIP_LEFT;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic             busy, rsp_strobe;
   rsp_item_type     rsp_item;
   int               fail_count, waiting_count;

   int idle_pct = 0;
   int fills = 0, plots = 0, reads = 0, clears = 0;

   // clip box per phase: left, top, right, bottom
   int clip_tbl [5][4] = '{'{0, 0, 320, 200}, '{17, 9, 303, 190}, '{320, 200, 0, 0},
                           '{5, 3, 6, 4}, '{160, 100, 320, 200}};
   int idle_tbl [5] = '{0, 88, 11, 0, 88};
   int count_tbl [5] = '{150, 130, 40, 40, 150};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bitplane_box_fill_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bbfe_checker pixel_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   function automatic req_item_type make_cmd(req_kind_type kind, int x, int y,
                                             int w, int h, logic [3:0] c);
      req_item_type it;
      it.req_type    = kind;
      it.pos_x       = 12'(x);
      it.pos_y       = 12'(y);
      it.rect_width  = 12'(w);
      it.rect_height = 12'(h);
      it.colour      = c;
      return it;
   endfunction

   // Mostly on-screen positions and small boxes; some raw 12-bit values and
   // a few large boxes, which are slow.
   function automatic req_item_type make_random_cmd();
      int roll, x, y, w, h;
      req_kind_type kind;
      roll = $urandom_range(99);
      if (roll < 1)       kind = REQ_CLEAR;
      else if (roll < 42) kind = REQ_FILL;
      else if (roll < 71) kind = REQ_PLOT;
      else                kind = REQ_READ;
      if ($urandom_range(99) < 85) begin
         x = $urandom_range(367) - 24;
         y = $urandom_range(247) - 24;
      end else begin
         x = $urandom_range(4095);
         y = $urandom_range(4095);
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
         w = $urandom_range(1, 40);
         h = $urandom_range(1, 6);
      end else if (roll < 88) begin
         w = $urandom_range(12) - 8;
         h = $urandom_range(12) - 8;
      end else if (roll < 92) begin
         w = $urandom_range(400);
         h = $urandom_range(220);
      end else begin
         w = $urandom_range(4095);
         h = $urandom_range(4095);
      end
      return make_cmd(kind, x, y, w, h, 4'($urandom_range(15)));
   endfunction

   // Presents one item and returns in the time step where it was taken.
   task automatic send_cmd(input req_item_type it);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      case (req_kind_type'(it.req_type))
         REQ_FILL: fills++;
         REQ_PLOT: plots++;
         REQ_READ: reads++;
         default:  clears++;
      endcase
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clip(input int l, input int t, input int r, input int b);
      csr_we    <= 1'b1;
      csr_index <= CSR_CLIP_LEFT;
      csr_wdata <= CSR_W'(l);
      @(posedge clock);
      csr_index <= CSR_CLIP_TOP;
      csr_wdata <= CSR_W'(t);
      @(posedge clock);
      csr_index <= CSR_CLIP_RIGHT;
      csr_wdata <= CSR_W'(r);
      @(posedge clock);
      csr_index <= CSR_CLIP_BOTTOM;
      csr_wdata <= CSR_W'(b);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // wait out the store sweep after reset
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      write_clip(0, 0, 320, 200);

      send_cmd(make_cmd(REQ_READ, 0, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_FILL, -5, -3, 2047, 2047, 4'hA));     // whole screen
      send_cmd(make_cmd(REQ_READ, 319, 199, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 0, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_FILL, 3, 5, 5, 2, 4'h5));             // inside one group
      send_cmd(make_cmd(REQ_FILL, 13, 20, 40, 3, 4'h0));          // edge masks + middle
      send_cmd(make_cmd(REQ_FILL, 10, 10, -2048, 4, 4'hF));       // negative width
      send_cmd(make_cmd(REQ_FILL, 10, 10, 4, -1, 4'hF));          // negative height
      send_cmd(make_cmd(REQ_FILL, 2047, 2047, 2047, 2047, 4'hF)); // past the store
      send_cmd(make_cmd(REQ_FILL, -2048, -2048, 2047, 5, 4'hF));  // ends left of screen
      send_cmd(make_cmd(REQ_PLOT, 0, 0, 0, 0, 4'h1));
      send_cmd(make_cmd(REQ_PLOT, 319, 199, 0, 0, 4'h8));
      send_cmd(make_cmd(REQ_PLOT, 320, 0, 0, 0, 4'hF));
      send_cmd(make_cmd(REQ_PLOT, -1, 5, 0, 0, 4'hF));
      send_cmd(make_cmd(REQ_PLOT, -2048, 2047, 0, 0, 4'hF));
      send_cmd(make_cmd(REQ_READ, 0, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 319, 199, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 5, 5, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 14, 21, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, -1, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 320, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 0, 200, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 2047, -2048, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_CLEAR, 0, 0, 0, 0, 4'h0));
      send_cmd(make_cmd(REQ_READ, 100, 100, 0, 0, 4'h0));
      drain();

      for (int p = 0; p < 5; p++) begin
         write_clip(clip_tbl[p][0], clip_tbl[p][1], clip_tbl[p][2], clip_tbl[p][3]);
         idle_pct = idle_tbl[p];
         repeat (count_tbl[p]) send_cmd(make_random_cmd());
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d fills, %0d plots, %0d reads and %0d clears", fills, plots, reads,
               clears);
      $display("across 5 clip boxes, including an inverted and a single-pixel box");
      if (fail_count == 0 && waiting_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
